// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ffcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffcc_pkg
// Types and constants of the fixed frame command checker.
// ----------------------------------------------------------------------------
package ffcc_pkg;

   // ASCII characters used by the frame format
   localparam logic [7:0] CH_START = 8'h53;  // 'S'
   localparam logic [7:0] CH_END   = 8'h45;  // 'E'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

   // 'S' plus four header digits
   localparam int HEADER_BYTES = 5;
   // payload characters emitted at most
   localparam int MAX_CHARS    = 20;
   localparam int NCHAR_W      = 5;
   localparam int NUM_W        = 7;

   // result kinds
   typedef enum logic [1:0] {
      REPLY_ACK    = 2'd0,
      REPLY_REJECT = 2'd1,
      REPLY_CHAR   = 2'd2
   } reply_type;

   // frame-end event from parser to emitter
   typedef struct packed {
      logic                 valid;
      logic                 reject;
      logic [NUM_W-1:0]     command;
      logic [NUM_W-1:0]     arg_length;
      logic [NCHAR_W-1:0]   nchars;
   } frame_evt_type;

endpackage

// ===== hw/rtl/ffcc_frame_mem.sv =====
// ----------------------------------------------------------------------------
// ffcc_frame_mem
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffcc_frame_mem #(
   parameter int FRAME_BYTES = 26
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
   output logic [7:0]                     rd_data
);

   logic [7:0] mem [FRAME_BYTES];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ffcc_parser.sv =====
// ----------------------------------------------------------------------------
// ffcc_parser
// Stores incoming bytes, checks header and padding on the fly, and flags
// the end of each frame.
// ----------------------------------------------------------------------------
module ffcc_parser #(
   parameter int FRAME_BYTES = 26
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_accept,
   input  logic [7:0]                     byte_in,
   output logic                           wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output ffcc_pkg::frame_evt_type        evt
);

   localparam int ADDR_W   = $clog2(FRAME_BYTES);
   localparam int LAST_POS = FRAME_BYTES - 1;
   localparam int AREA     = FRAME_BYTES - ffcc_pkg::HEADER_BYTES - 1;
   localparam int LIMIT    = (AREA < ffcc_pkg::MAX_CHARS) ? AREA : ffcc_pkg::MAX_CHARS;

   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic                       hdr_ok_ff, hdr_ok_in;
   logic                       pad_ok_ff, pad_ok_in;
   logic [ffcc_pkg::NUM_W-1:0] cmd_ff, cmd_in;
   logic [ffcc_pkg::NUM_W-1:0] len_ff, len_in;

   logic                       take;
   logic                       is_digit;
   logic [3:0]                 digit;
   logic [ffcc_pkg::NUM_W-1:0] tens;
   logic [7:0]                 pos_w;
   logic                       at_end;
   logic                       frame_done;
   logic                       pad_zone;

   // byte decode
   assign take     = byte_accept && (byte_in != 8'd0);
   assign is_digit = (byte_in >= ffcc_pkg::CH_ZERO) && (byte_in <= ffcc_pkg::CH_NINE);
   assign digit    = byte_in[3:0];
   assign tens     = 7'({digit, 3'b000}) + 7'({digit, 1'b0});
   assign pos_w    = 8'(pos_ff);
   assign at_end   = (pos_w == 8'(LAST_POS));
   assign frame_done = at_end || (byte_in == ffcc_pkg::CH_END);
   assign pad_zone = (pos_w >= 8'(ffcc_pkg::HEADER_BYTES)) && !at_end &&
                     (pos_w >= (8'(len_ff) + 8'(ffcc_pkg::HEADER_BYTES)));

   // header, padding and count update
   always_comb begin
      hdr_ok_in = hdr_ok_ff;
      pad_ok_in = pad_ok_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      if (pos_w == 8'd0) begin
         hdr_ok_in = (byte_in == ffcc_pkg::CH_START);
         pad_ok_in = 1'b1;
      end else if (pos_w < 8'(ffcc_pkg::HEADER_BYTES)) begin
         hdr_ok_in = hdr_ok_ff && is_digit;
      end
      if (pos_w == 8'd1) cmd_in = tens;
      if (pos_w == 8'd2) cmd_in = cmd_ff + 7'(digit);
      if (pos_w == 8'd3) len_in = tens;
      if (pos_w == 8'd4) len_in = len_ff + 7'(digit);
      if (pad_zone && (byte_in != ffcc_pkg::CH_ZERO)) pad_ok_in = 1'b0;
      pos_in = frame_done ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hdr_ok_ff <= hdr_ok_in;
         pad_ok_ff <= pad_ok_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
      end
   end

   // store write
   assign wr_en   = take;
   assign wr_addr = pos_ff;
   assign wr_data = byte_in;

   // frame-end event; header and padding are final before the last byte
   always_comb begin
      evt.valid      = take && frame_done;
      evt.reject     = !(at_end && (byte_in == ffcc_pkg::CH_END) && hdr_ok_ff && pad_ok_ff);
      evt.command    = cmd_ff;
      evt.arg_length = len_ff;
      evt.nchars     = (len_ff > 7'(LIMIT)) ? 5'(LIMIT) : 5'(len_ff);
   end

endmodule

// ===== hw/rtl/ffcc_emitter.sv =====
// ----------------------------------------------------------------------------
// ffcc_emitter
// Sends the reject, or the acknowledge followed by payload characters read
// from the frame store into the output register.
// ----------------------------------------------------------------------------
module ffcc_emitter #(
   parameter int FRAME_BYTES = 26
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ffcc_pkg::frame_evt_type        evt,
   output logic                           busy,
   output logic                           rd_en,
   output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int ADDR_W = $clog2(FRAME_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HEAD = 4'b0010,
      ST_READ = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic                         reject_ff;
   logic [ffcc_pkg::NUM_W-1:0]   cmd_ff;
   logic [ffcc_pkg::NUM_W-1:0]   len_ff;
   logic [ffcc_pkg::NCHAR_W-1:0] nch_ff;
   logic [ffcc_pkg::NCHAR_W-1:0] idx_ff, idx_in;

   logic                         out_valid_ff, out_valid_in;
   ffcc_pkg::reply_type          out_reply_ff, out_reply_in;
   logic [ffcc_pkg::NUM_W-1:0]   out_cmd_ff, out_cmd_in;
   logic [ffcc_pkg::NUM_W-1:0]   out_len_ff, out_len_in;
   logic [7:0]                   out_char_ff, out_char_in;
   logic                         out_last_ff, out_last_in;

   logic                         out_free;
   logic                         char_last;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign char_last = (idx_ff + 1'b1) == nch_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_en        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_reply_in = out_reply_ff;
      out_cmd_in   = out_cmd_ff;
      out_len_in   = out_len_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (evt.valid) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = 8'd0;
               if (reject_ff) begin
                  out_reply_in = ffcc_pkg::REPLY_REJECT;
                  out_cmd_in   = '0;
                  out_len_in   = '0;
                  out_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  out_reply_in = ffcc_pkg::REPLY_ACK;
                  out_cmd_in   = cmd_ff;
                  out_len_in   = len_ff;
                  out_last_in  = (nch_ff == '0);
                  idx_in       = '0;
                  state_in     = (nch_ff == '0) ? ST_IDLE : ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_reply_in = ffcc_pkg::REPLY_CHAR;
               out_cmd_in   = '0;
               out_len_in   = '0;
               out_char_in  = rd_data;
               out_last_in  = char_last;
               idx_in       = idx_ff + 1'b1;
               state_in     = char_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // payload positions start after the header
   assign rd_addr = ADDR_W'(8'(idx_ff) + 8'(ffcc_pkg::HEADER_BYTES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      out_reply_ff <= out_reply_in;
      out_cmd_ff   <= out_cmd_in;
      out_len_ff   <= out_len_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      if ((state_ff == ST_IDLE) && evt.valid) begin
         reject_ff <= evt.reject;
         cmd_ff    <= evt.command;
         len_ff    <= evt.arg_length;
         nch_ff    <= evt.nchars;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_char_ff, out_len_ff, out_cmd_ff, out_reply_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/fixed_frame_command_checker_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_frame_command_checker_unit
// Collects fixed-size command frames from a byte stream, checks them and
// answers with a reject, or an acknowledge followed by payload characters.
//
//   channel   dir  fields                                     handshake
//   req_      in   tdata: rx_byte                             tvalid/tready
//   rsp_      out  tdata: reply,command,arg_length,arg_char   tvalid/tready
//                  tlast: last
//
// A byte that does not close a frame is taken while ready stays high.
// A frame-closing byte drops ready while the answer is sent: a reject, or an
// acknowledge followed by a store read and then a send per payload character,
// with each send held while the output register waits on rsp_tready.
// Reset clears the byte position and the sequencer; the frame store needs
// no clearing, every byte checked or sent is written in the same frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_frame_command_checker_unit #(
   parameter int FRAME_BYTES = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] reply, [8:2] command,
                                    // [15:9] arg_length, [23:16] arg_char
   output logic        rsp_tlast    // last
);

   localparam int ADDR_W = $clog2(FRAME_BYTES);

   logic                    busy;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [7:0]              wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [7:0]              rd_data;
   ffcc_pkg::frame_evt_type evt;
   logic                    rsp_is_reject;
   logic                    rsp_is_empty_ack;

   // bytes are taken only while no frame answer is in progress
   assign req_tready = !busy;

   ffcc_parser #(.FRAME_BYTES(FRAME_BYTES)) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_tvalid && req_tready),
      .byte_in     (req_tdata),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .evt         (evt)
   );

   ffcc_frame_mem #(.FRAME_BYTES(FRAME_BYTES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ffcc_emitter #(.FRAME_BYTES(FRAME_BYTES)) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // result kind decode for the checks
   assign rsp_is_reject    = rsp_tvalid && (rsp_tdata[1:0] == ffcc_pkg::REPLY_REJECT);
   assign rsp_is_empty_ack = rsp_tvalid && (rsp_tdata[1:0] == ffcc_pkg::REPLY_ACK) &&
                             (rsp_tdata[15:9] == 7'd0);

   // checks
   `ASSERT_NEXT(a_evt_busy, clock, reset, evt.valid, busy, "frame end did not start answer")
   `ASSERT_ALWAYS(a_no_rw_overlap, clock, reset, !(wr_en && rd_en), "store write during read")
   `ASSERT_SAME(a_reject_last, clock, reset, rsp_is_reject, rsp_tlast, "reject without last")
   `ASSERT_SAME(a_empty_ack_last, clock, reset, rsp_is_empty_ack, rsp_tlast, "empty ack no last")

endmodule
